>>> sv/hnm_pkg.sv
// Shared types, constants and helpers for the height field normal map unit.
// No dependencies.
package hnm_pkg;

  localparam int unsigned MAX_SIDE_DEF  = 2048;
  localparam logic [11:0] GRID_SIDE_RST = 12'd1025;
  localparam int unsigned ZB            = 17;  // unit z scaled by 2^ZB
  localparam int unsigned FRAC          = 15;  // output fraction bits
  localparam int unsigned QB            = 17;  // quotient bits per division

  localparam logic [1:0] RD_XA = 2'd0;
  localparam logic [1:0] RD_XB = 2'd1;
  localparam logic [1:0] RD_YA = 2'd2;
  localparam logic [1:0] RD_YB = 2'd3;

  localparam logic [1:0] CMP_X = 2'd0;
  localparam logic [1:0] CMP_Y = 2'd1;
  localparam logic [1:0] CMP_Z = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       pick;
    logic [1:0] pick_idx;
    logic       last;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mul_en;
    logic       mul_sel;
    logic       sqx;
    logic       sqy;
    logic       sum;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic [1:0] div_sel;
  } hnm_cmd_t;

  typedef struct packed {
    logic e_emit;
    logic e_lastcol;
    logic e_lastrow;
  } hnm_sts_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

>>> sv/hnm_datapath.sv
// Datapath: grid counters, three-row height store, slope multiplier,
// iterative square root and shared divider. Depends on hnm_pkg.
module hnm_datapath
  import hnm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               grid_side_we_i,
  input  logic [11:0]        grid_side_i,
  input  logic [15:0]        height_i,
  input  hnm_cmd_t           cmd_i,
  output hnm_sts_t           sts_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [14:0]        normal_z_o,
  output logic [10:0]        column_o,
  output logic [10:0]        row_o,
  output logic               last_of_run_o
);

  localparam int unsigned NW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned MW    = 17 + NW;
  localparam int unsigned VW    = MW + 1;
  localparam int unsigned SW    = 2 * MW + 2;
  localparam int unsigned RW    = MW + 1;
  localparam int unsigned NUMW  = MW + 16;
  localparam int unsigned DEPTH = 3 * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [11:0]          grid_side_q;
  logic [CW-1:0]        col_q, row_q, ic_q, ir_q, tc_q, tr_q, tc_d, tr_d;
  logic [1:0]           slot_q, islot_q, tslot_q, tslot_d;
  logic [15:0]          mem [DEPTH];
  logic [15:0]          rdata_q;
  logic [15:0]          h_q [4];
  logic signed [VW-1:0] vx_q, vy_q;
  logic [2*MW-1:0]      sqx_q, sqy_q;
  logic [SW-1:0]        rem_q, res_q, bit_q;
  logic [RW-1:0]        drem_q;
  logic [QB-1:0]        dnum_q, quo_q;

  logic [NW-1:0]        n_w;
  logic [31:0]          nm1;
  logic                 t_c0, t_cl, t_r0, t_rl;
  logic [CW-1:0]        rc;
  logic [1:0]           rs;
  logic [AW-1:0]        waddr, raddr;
  logic signed [16:0]   dm;
  logic signed [VW-1:0] prod, vm;
  logic                 one_sided;
  logic [MW-1:0]        ax, ay, mag;
  logic [SW-1:0]        trial;
  logic [RW-1:0]        rt;
  logic [NUMW-1:0]      num;
  logic [RW:0]          dt;
  logic                 ge;
  logic [14:0]          qs;

  always_comb begin
    if (grid_side_q < 12'd3) begin
      n_w = NW'(3);
    end else if (32'(grid_side_q) > MAX_SIDE) begin
      n_w = NW'(MAX_SIDE);
    end else begin
      n_w = NW'(grid_side_q);
    end
  end

  assign nm1             = 32'(n_w) - 32'd1;
  assign sts_o.e_emit    = (row_q != '0) && (col_q != '0);
  assign sts_o.e_lastcol = 32'(col_q) == nm1;
  assign sts_o.e_lastrow = 32'(row_q) == nm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
    end else if (grid_side_we_i) begin
      grid_side_q <= grid_side_i;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
    end else if (cmd_i.accept) begin
      if (sts_o.e_lastcol) begin
        col_q <= '0;
        if (sts_o.e_lastrow) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + CW'(1);
          slot_q <= slot_inc(slot_q);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // target point of the request being worked on
  always_comb begin
    case (cmd_i.pick_idx)
      2'd0: begin
        tc_d = ic_q - CW'(1); tr_d = ir_q - CW'(1); tslot_d = slot_dec(islot_q);
      end
      2'd1: begin
        tc_d = ic_q;          tr_d = ir_q - CW'(1); tslot_d = slot_dec(islot_q);
      end
      2'd2: begin
        tc_d = ic_q - CW'(1); tr_d = ir_q;          tslot_d = islot_q;
      end
      default: begin
        tc_d = ic_q;          tr_d = ir_q;          tslot_d = islot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ic_q    <= col_q;
      ir_q    <= row_q;
      islot_q <= slot_q;
    end
    if (cmd_i.pick) begin
      tc_q          <= tc_d;
      tr_q          <= tr_d;
      tslot_q       <= tslot_d;
      column_o      <= 11'(tc_d);
      row_o         <= 11'(tr_d);
      last_of_run_o <= cmd_i.last;
    end
  end

  assign t_c0 = tc_q == '0;
  assign t_cl = 32'(tc_q) == nm1;
  assign t_r0 = tr_q == '0;
  assign t_rl = 32'(tr_q) == nm1;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_XA: begin
        rs = tslot_q;
        rc = t_c0 ? CW'(1) : (t_cl ? tc_q : tc_q + CW'(1));
      end
      RD_XB: begin
        rs = tslot_q;
        rc = t_c0 ? '0 : tc_q - CW'(1);
      end
      RD_YA: begin
        rs = t_rl ? tslot_q : slot_inc(tslot_q);
        rc = tc_q;
      end
      default: begin
        rs = t_r0 ? tslot_q : slot_dec(tslot_q);
        rc = tc_q;
      end
    endcase
  end

  assign waddr = AW'(32'(slot_q) * MAX_SIDE + 32'(col_q));
  assign raddr = AW'(32'(rs) * MAX_SIDE + 32'(rc));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[waddr] <= height_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // slope: v = -(a - b) * n, doubled for a one-sided difference
  always_comb begin
    if (cmd_i.mul_sel) begin
      dm        = $signed({1'b0, h_q[2]}) - $signed({1'b0, h_q[3]});
      one_sided = t_r0 || t_rl;
    end else begin
      dm        = $signed({1'b0, h_q[0]}) - $signed({1'b0, h_q[1]});
      one_sided = t_c0 || t_cl;
    end
    prod = VW'(dm) * VW'($signed({1'b0, n_w}));
    vm   = one_sided ? (prod <<< 1) : prod;
  end

  assign ax    = MW'(vx_q[VW-1] ? -vx_q : vx_q);
  assign ay    = MW'(vy_q[VW-1] ? -vy_q : vy_q);
  assign trial = res_q + bit_q;
  assign rt    = RW'(res_q);

  always_comb begin
    case (cmd_i.div_sel)
      CMP_X:   mag = ax;
      CMP_Y:   mag = ay;
      default: mag = MW'(1) << ZB;
    endcase
    num = (NUMW'(mag) << FRAC) + NUMW'(rt >> 1);
    dt  = {drem_q, dnum_q[QB-1]};
    ge  = dt >= {1'b0, rt};
    qs  = (quo_q > QB'(32767)) ? 15'd32767 : quo_q[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      h_q[cmd_i.cap_sel] <= rdata_q;
    end
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel) begin
        vy_q <= -vm;
      end else begin
        vx_q <= -vm;
      end
    end
    if (cmd_i.sqx) begin
      sqx_q <= (2*MW)'(ax) * (2*MW)'(ax);
    end
    if (cmd_i.sqy) begin
      sqy_q <= (2*MW)'(ay) * (2*MW)'(ay);
    end
    if (cmd_i.sum) begin
      rem_q <= SW'(sqx_q) + SW'(sqy_q) + (SW'(1) << (2 * ZB));
      res_q <= '0;
      bit_q <= SW'(1) << (SW - 2);
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      drem_q <= RW'(num >> QB);
      dnum_q <= num[QB-1:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      drem_q <= ge ? RW'(dt - {1'b0, rt}) : RW'(dt);
      dnum_q <= dnum_q << 1;
      quo_q  <= {quo_q[QB-2:0], ge};
    end
    if (cmd_i.div_fin) begin
      case (cmd_i.div_sel)
        CMP_X:   normal_x_o <= vx_q[VW-1] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        CMP_Y:   normal_y_o <= vy_q[VW-1] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        default: normal_z_o <= qs;
      endcase
    end
  end

endmodule

>>> sv/hnm_ctrl.sv
// Controller: sequences requests per item, reads, arithmetic steps and
// the output handshake. Depends on hnm_pkg.
module hnm_ctrl
  import hnm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     height_valid_i,
  output logic     height_ready_o,
  output logic     normal_valid_o,
  input  logic     normal_ready_i,
  input  hnm_sts_t sts_i,
  output hnm_cmd_t cmd_o
);

  localparam int unsigned NW   = $clog2(MAX_SIDE + 1);
  localparam int unsigned RW   = 18 + NW;
  localparam int unsigned CNTW = $clog2(RW + QB + 5);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PICK = 13'b0000000000010,
    S_READ = 13'b0000000000100,
    S_MULX = 13'b0000000001000,
    S_MULY = 13'b0000000010000,
    S_SQX  = 13'b0000000100000,
    S_SQY  = 13'b0000001000000,
    S_SUM  = 13'b0000010000000,
    S_SQRT = 13'b0000100000000,
    S_DIVI = 13'b0001000000000,
    S_DIVS = 13'b0010000000000,
    S_DIVF = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } hnm_state_e;

  hnm_state_e      state_q, state_d;
  logic [3:0]      mask_q, mask_d, low;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0]      comp_q, comp_d, idx;

  always_comb begin
    if (mask_q[0]) begin
      idx = 2'd0; low = 4'b0001;
    end else if (mask_q[1]) begin
      idx = 2'd1; low = 4'b0010;
    end else if (mask_q[2]) begin
      idx = 2'd2; low = 4'b0100;
    end else begin
      idx = 2'd3; low = 4'b1000;
    end
  end

  assign height_ready_o = state_q == S_IDLE;
  assign normal_valid_o = state_q == S_OUT;

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    cmd_o   = '0;
    cmd_o.pick_idx = idx;
    cmd_o.last     = (mask_q & ~low) == 4'b0000;
    cmd_o.rd_sel   = cnt_q[1:0];
    cmd_o.cap_sel  = 2'(cnt_q - CNTW'(1));
    cmd_o.div_sel  = comp_q;
    case (state_q)
      S_IDLE: begin
        if (height_valid_i) begin
          cmd_o.accept = 1'b1;
          mask_d = {sts_i.e_emit & sts_i.e_lastcol & sts_i.e_lastrow,
                    sts_i.e_emit & sts_i.e_lastrow,
                    sts_i.e_emit & sts_i.e_lastcol,
                    sts_i.e_emit};
          state_d = sts_i.e_emit ? S_PICK : S_IDLE;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        mask_d  = mask_q & ~low;
        cnt_d   = '0;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en  = cnt_q < CNTW'(4);
        cmd_o.cap_en = cnt_q != '0;
        if (cnt_q == CNTW'(4)) begin
          state_d = S_MULX;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_MULX: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 1'b1;
        state_d = S_SQX;
      end
      S_SQX: begin
        cmd_o.sqx = 1'b1;
        state_d = S_SQY;
      end
      S_SQY: begin
        cmd_o.sqy = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CNTW'(RW - 1)) begin
          comp_d  = CMP_X;
          state_d = S_DIVI;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNTW'(QB - 1)) begin
          state_d = S_DIVF;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_DIVF: begin
        cmd_o.div_fin = 1'b1;
        if (comp_q == CMP_Z) begin
          state_d = S_OUT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DIVI;
        end
      end
      S_OUT: begin
        if (normal_ready_i) begin
          state_d = (mask_q != 4'b0000) ? S_PICK : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q  <= '0;
      cnt_q   <= '0;
      comp_q  <= CMP_X;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

endmodule

>>> sv/heightfield_normal_map_unit.sv
// Height field to normal map: one request in, up to four normals out.
// Each normal is computed by the bit-serial square root (RW steps) and the
// shared divider (QB steps for each of three components). One item in flight;
// ready only when idle.
// Reset (async, active low) idles the unit, grid_side to 1025, frame at origin.
module heightfield_normal_map_unit
  import hnm_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               grid_side_we_i,
  input  logic [11:0]        grid_side_i,
  input  logic               height_valid_i,
  output logic               height_ready_o,
  input  logic [15:0]        height_i,
  output logic               normal_valid_o,
  input  logic               normal_ready_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [14:0]        normal_z_o,
  output logic [10:0]        column_o,
  output logic [10:0]        row_o,
  output logic               last_of_run_o
);

  hnm_cmd_t cmd;
  hnm_sts_t sts;

  hnm_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk_i,
    .rst_ni,
    .height_valid_i,
    .height_ready_o,
    .normal_valid_o,
    .normal_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  hnm_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
    .clk_i,
    .rst_ni,
    .grid_side_we_i,
    .grid_side_i,
    .height_i,
    .cmd_i (cmd),
    .sts_o (sts),
    .normal_x_o,
    .normal_y_o,
    .normal_z_o,
    .column_o,
    .row_o,
    .last_of_run_o
  );

endmodule
